@@ hdl/btpc_pkg.sv @@
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies.
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int unsigned RawW = 20;
  localparam int unsigned TempW = 24;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueIdxW = 2;
  localparam int unsigned PipeDepth = 24;

  localparam logic [CfgIdxW-1:0] RegTempCal = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressLow = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressHigh = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressLast = 2'd3;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_low;
    logic [63:0] press_high;
    logic [15:0] press_last;
  } cal_t;

  // Occupancy flags of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] x, input int n);
    return WordW'($signed(x) >>> n);
  endfunction

endpackage

@@ hdl/barometric_temp_pressure_compensate_top.sv @@
// Top level of the barometric compensation block: config registers, queue, datapath.
// Depends on btpc_pkg, btpc_front, btpc_back (and btpc_div below it).
`timescale 1ns / 1ps
//
//  channel   | signals                                   | direction | handshake
//  ----------+-------------------------------------------+-----------+---------------------
//  command   | start, busy, raw_pressure, raw_temperature| in        | start && !busy
//  result    | done, temperature_centi, pressure_pa,     | out       | done for one cycle
//            | divide_by_zero                            |           |
//  config    | cfg_we, cfg_index, cfg_data               | in        | cfg_we, no wait
//
//  One word per cycle sustained; an accepted word passes one queue slot, then the 11
//  arithmetic stages ahead of the divider, the 32 stages of the divider and 3 correction
//  stages after it.
//  The back end never stalls since the receiver cannot hold results off, so busy
//  only rises if the queue fills, which it never does at one word per cycle.
//  Synchronous active-high rst clears control state and calibration registers.
module barometric_temp_pressure_compensate_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [btpc_pkg::RawW-1:0]             raw_pressure,
  input  logic [btpc_pkg::RawW-1:0]             raw_temperature,
  output logic                                  done,
  output logic signed [btpc_pkg::TempW-1:0]     temperature_centi,
  output logic [btpc_pkg::WordW-1:0]            pressure_pa,
  output logic                                  divide_by_zero,
  input  logic                                  cfg_we,
  input  logic [btpc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [btpc_pkg::CfgW-1:0]             cfg_data
);

  btpc_pkg::cal_t cal;

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::RegTempCal:   cal.temp_cal   <= cfg_data[47:0];
        btpc_pkg::RegPressLow:  cal.press_low  <= cfg_data;
        btpc_pkg::RegPressHigh: cal.press_high <= cfg_data;
        btpc_pkg::RegPressLast: cal.press_last <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  btpc_pkg::sample_t        in_word, head;
  btpc_pkg::queue_status_t  qstat;
  logic                     accept, pop;

  assign in_word.raw_pressure    = raw_pressure;
  assign in_word.raw_temperature = raw_temperature;
  assign busy   = qstat.full;
  assign accept = start && !busy;
  // The back end takes a word every cycle the queue holds one.
  assign pop    = !qstat.empty;

  btpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (in_word),
    .pop       (pop),
    .head      (head),
    .status    (qstat)
  );

  logic [btpc_pkg::TempW-1:0] temp_u;

  btpc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (pop),
    .sample            (head),
    .cal               (cal),
    .out_valid         (done),
    .temperature_centi (temp_u),
    .pressure_pa       (pressure_pa),
    .divide_by_zero    (divide_by_zero)
  );

  assign temperature_centi = $signed(temp_u);

  // A zero divisor always forces the pressure to zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_by_zero |-> pressure_pa == '0)
    else $error("pressure nonzero on divide by zero");

  // The queue never holds off a command since it drains every cycle.
  a_never_busy_after_idle: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |=> !busy)
    else $error("busy raised after empty queue");

  // A popped word is only taken from a non-empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

@@ hdl/btpc_front.sv @@
// Front end: takes command words into a short queue of samples.
// Depends on btpc_pkg.
`timescale 1ns / 1ps
module btpc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  btpc_pkg::sample_t           push_word,
  input  logic                        pop,
  output btpc_pkg::sample_t           head,
  output btpc_pkg::queue_status_t     status
);

  btpc_pkg::sample_t slots [btpc_pkg::QueueDepth];
  logic [btpc_pkg::QueueIdxW-1:0] wr_ptr;
  logic [btpc_pkg::QueueIdxW-1:0] rd_ptr;
  logic [btpc_pkg::QueueIdxW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (btpc_pkg::QueueIdxW+1)'(push) - (btpc_pkg::QueueIdxW+1)'(pop);
    end
  end

  assign head = slots[rd_ptr];
  assign status.full = (count == (btpc_pkg::QueueIdxW+1)'(btpc_pkg::QueueDepth));
  assign status.empty = (count == '0);

endmodule

@@ hdl/btpc_div.sv @@
// Restoring unsigned 32/32 divider, one quotient bit per stage, fully pipelined.
// Depends on btpc_pkg. Carries a tag word alongside.
`timescale 1ns / 1ps
module btpc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [btpc_pkg::WordW-1:0]  dividend,
  input  logic [btpc_pkg::WordW-1:0]  divisor,
  input  logic [63:0]                 tag_in,
  output logic                        out_valid,
  output logic [btpc_pkg::WordW-1:0]  quotient,
  output logic [63:0]                 tag_out
);
  localparam int unsigned W = btpc_pkg::WordW;

  logic [W-1:0]  rem  [W+1];
  logic [W-1:0]  quo  [W+1];
  logic [W-1:0]  dvs  [W+1];
  logic [63:0]   tag  [W+1];
  logic          vld  [W+1];

  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;
  assign tag[0] = tag_in;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    assign trial = {rem[s], quo[s][W-1]};
    assign diff  = trial - {1'b0, dvs[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      rem[s+1] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
      quo[s+1] <= {quo[s][W-2:0], ~diff[W]};
      dvs[s+1] <= dvs[s];
      tag[s+1] <= tag[s];
    end
  end

  assign out_valid = vld[W];
  assign quotient  = quo[W];
  assign tag_out   = tag[W];

endmodule

@@ hdl/btpc_back.sv @@
// Back end: pipelined compensation datapath, one sample per cycle.
// Depends on btpc_pkg and btpc_div.
`timescale 1ns / 1ps
module btpc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  btpc_pkg::sample_t           sample,
  input  btpc_pkg::cal_t              cal,
  output logic                        out_valid,
  output logic [btpc_pkg::TempW-1:0]  temperature_centi,
  output logic [btpc_pkg::WordW-1:0]  pressure_pa,
  output logic                        divide_by_zero
);
  localparam int unsigned W = btpc_pkg::WordW;
  typedef logic [W-1:0] w_t;

  w_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, cal.temp_cal[15:0]};
  assign t2 = btpc_pkg::sx16(cal.temp_cal[31:16]);
  assign t3 = btpc_pkg::sx16(cal.temp_cal[47:32]);
  assign p1 = {16'd0, cal.press_low[15:0]};
  assign p2 = btpc_pkg::sx16(cal.press_low[31:16]);
  assign p3 = btpc_pkg::sx16(cal.press_low[47:32]);
  assign p4 = btpc_pkg::sx16(cal.press_low[63:48]);
  assign p5 = btpc_pkg::sx16(cal.press_high[15:0]);
  assign p6 = btpc_pkg::sx16(cal.press_high[31:16]);
  assign p7 = btpc_pkg::sx16(cal.press_high[47:32]);
  assign p8 = btpc_pkg::sx16(cal.press_high[63:48]);
  assign p9 = btpc_pkg::sx16(cal.press_last);

  // s1: operand differences
  logic v1; w_t s1_x, s1_d; logic [btpc_pkg::RawW-1:0] s1_p;
  // s2: first products
  logic v2; w_t s2_a, s2_dd; logic [btpc_pkg::RawW-1:0] s2_p;
  // s3
  logic v3; w_t s3_a, s3_b; logic [btpc_pkg::RawW-1:0] s3_p;
  // s4: fine
  logic v4; w_t s4_fine; logic [btpc_pkg::RawW-1:0] s4_p;
  // s5: temp and pressure var1
  logic v5; w_t s5_t5, s5_a, s5_qh; logic [btpc_pkg::RawW-1:0] s5_p;
  // s6
  logic v6; w_t s6_temp, s6_q, s6_a5, s6_p2a, s6_a; logic [btpc_pkg::RawW-1:0] s6_p;
  // s7
  logic v7; w_t s7_temp, s7_b1, s7_a5, s7_p3q, s7_p2a; logic [btpc_pkg::RawW-1:0] s7_p;
  // s8
  logic v8; w_t s8_temp, s8_b, s8_a; logic [btpc_pkg::RawW-1:0] s8_p;
  // s9
  logic v9; w_t s9_temp, s9_b, s9_a; logic [btpc_pkg::RawW-1:0] s9_p;
  // s10
  logic v10; w_t s10_temp, s10_x, s10_a;
  // s11
  logic v11; w_t s11_temp, s11_pres, s11_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <= '0;
    end else begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <=
        {in_valid, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10};
    end
  end

  always_ff @(posedge clk) begin
    s1_x <= w_t'(sample.raw_temperature >> 3) - (t1 << 1);
    s1_d <= w_t'(sample.raw_temperature >> 4) - t1;
    s1_p <= sample.raw_pressure;

    s2_a  <= btpc_pkg::asr(s1_x * t2, 11);
    s2_dd <= btpc_pkg::asr(s1_d * s1_d, 12);
    s2_p  <= s1_p;

    s3_a <= s2_a;
    s3_b <= btpc_pkg::asr(s2_dd * t3, 14);
    s3_p <= s2_p;

    s4_fine <= s3_a + s3_b;
    s4_p    <= s3_p;

    s5_t5 <= s4_fine * 32'd5 + 32'd128;
    s5_a  <= btpc_pkg::asr(s4_fine, 1) - 32'd64000;
    s5_qh <= btpc_pkg::asr(btpc_pkg::asr(s4_fine, 1) - 32'd64000, 2);
    s5_p  <= s4_p;

    s6_temp <= btpc_pkg::asr(s5_t5, 8);
    s6_q    <= s5_qh * s5_qh;
    s6_a5   <= (s5_a * p5) << 1;
    s6_p2a  <= btpc_pkg::asr(p2 * s5_a, 1);
    s6_a    <= s5_a;
    s6_p    <= s5_p;

    s7_temp <= s6_temp;
    s7_b1   <= btpc_pkg::asr(s6_q, 11) * p6;
    s7_a5   <= s6_a5;
    s7_p3q  <= p3 * btpc_pkg::asr(s6_q, 13);
    s7_p2a  <= s6_p2a;
    s7_p    <= s6_p;

    s8_temp <= s7_temp;
    s8_b    <= btpc_pkg::asr(s7_b1 + s7_a5, 2) + (p4 << 16);
    s8_a    <= btpc_pkg::asr(btpc_pkg::asr(s7_p3q, 3) + s7_p2a, 18);
    s8_p    <= s7_p;

    s9_temp <= s8_temp;
    s9_b    <= s8_b;
    s9_a    <= (32'd32768 + s8_a) * p1;
    s9_p    <= s8_p;

    s10_temp <= s9_temp;
    s10_a    <= btpc_pkg::asr(s9_a, 15);
    s10_x    <= (32'd1048576 - w_t'(s9_p)) - btpc_pkg::asr(s9_b, 12);

    s11_temp <= s10_temp;
    s11_a    <= s10_a;
    s11_pres <= s10_x * 32'd3125;
  end

  // Divide: small dividends are doubled first, large ones have the quotient doubled.
  logic       big;
  w_t         div_num;
  logic       dv_valid;
  w_t         dv_q;
  logic [63:0] dv_tag;
  assign big = s11_pres[W-1];
  assign div_num = big ? s11_pres : (s11_pres << 1);

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v11),
    .dividend  (div_num),
    .divisor   (s11_a),
    .tag_in    ({s11_temp, 30'd0, big, (s11_a == '0)}),
    .out_valid (dv_valid),
    .quotient  (dv_q),
    .tag_out   (dv_tag)
  );

  // Post divide correction.
  logic v12, v13, v14;
  w_t s12_pres, s13_pres, s13_a, s13_b, s14_pres;
  logic [31:0] s12_temp, s13_temp, s14_temp;
  logic s12_dz, s13_dz, s14_dz;
  w_t s12_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v12, v13, v14} <= '0;
    end else begin
      {v12, v13, v14} <= {dv_valid, v12, v13};
    end
  end

  always_ff @(posedge clk) begin
    s12_temp <= dv_tag[63:32];
    s12_dz   <= dv_tag[0];
    s12_pres <= dv_tag[1] ? (dv_q << 1) : dv_q;
    s12_d    <= '0;

    s13_temp <= s12_temp;
    s13_dz   <= s12_dz;
    s13_pres <= s12_pres;
    s13_a    <= (s12_pres >> 3) * (s12_pres >> 3);
    s13_b    <= btpc_pkg::asr((s12_pres >> 2) * p8, 13) + s12_d;

    s14_temp <= s13_temp;
    s14_dz   <= s13_dz;
    s14_pres <= s13_dz ? '0 :
                s13_pres + btpc_pkg::asr(btpc_pkg::asr(p9 * (s13_a >> 13), 12)
                                         + s13_b + p7, 4);
  end

  assign out_valid         = v14;
  assign temperature_centi = s14_temp[btpc_pkg::TempW-1:0];
  assign pressure_pa       = s14_pres;
  assign divide_by_zero    = s14_dz;

endmodule

@@ test/barometric_temp_pressure_compensate_top_tb.sv @@
// Testbench for the barometric compensation block: directed and random samples
// checked against a behavioral 32-bit integer compensation predictor.
// Depends on btpc_pkg and barometric_temp_pressure_compensate_top.
`timescale 1ns / 1ps
module barometric_temp_pressure_compensate_top_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [btpc_pkg::TempW-1:0] temperature_centi;
    logic [btpc_pkg::WordW-1:0] pressure_pa;
    logic                       divide_by_zero;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [btpc_pkg::RawW-1:0] raw_pressure = '0;
  logic [btpc_pkg::RawW-1:0] raw_temperature = '0;
  logic done;
  logic signed [btpc_pkg::TempW-1:0] temperature_centi;
  logic [btpc_pkg::WordW-1:0] pressure_pa;
  logic divide_by_zero;
  logic cfg_we = 1'b0;
  logic [btpc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [btpc_pkg::CfgW-1:0] cfg_data = '0;

  barometric_temp_pressure_compensate_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
    .done(done), .temperature_centi(temperature_centi), .pressure_pa(pressure_pa),
    .divide_by_zero(divide_by_zero),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the calibration registers.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_low, cal_press_high;
  logic [15:0] cal_press_last;

  comp_result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned zero_div_seen = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  bit quiet_sender = 1'b0;  // long stretch without gaps

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // 32-bit wrapping integer compensation, same arithmetic as the sensor datasheet form.
  function automatic comp_result_t compensate(logic [19:0] adc_p, logic [19:0] adc_t);
    comp_result_t r;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, fine, temp, pres, ap, at;
    ap = {12'd0, adc_p};
    at = {12'd0, adc_t};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sext16(cal_temp[31:16]);
    t3 = sext16(cal_temp[47:32]);
    p1 = {16'd0, cal_press_low[15:0]};
    p2 = sext16(cal_press_low[31:16]);
    p3 = sext16(cal_press_low[47:32]);
    p4 = sext16(cal_press_low[63:48]);
    p5 = sext16(cal_press_high[15:0]);
    p6 = sext16(cal_press_high[31:16]);
    p7 = sext16(cal_press_high[47:32]);
    p8 = sext16(cal_press_high[63:48]);
    p9 = sext16(cal_press_last);
    a = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = sra32(sra32(d * d, 12) * t3, 14);
    fine = a + b;
    temp = sra32(fine * 32'd5 + 32'd128, 8);
    a = sra32(fine, 1) - 32'd64000;
    q = sra32(a, 2) * sra32(a, 2);
    b = sra32(q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra32(b, 2) + (p4 << 16);
    a = sra32(sra32(p3 * sra32(q, 13), 3) + sra32(p2 * a, 1), 18);
    a = sra32((32'd32768 + a) * p1, 15);
    r.divide_by_zero = (a == 0);
    if (a == 0) begin
      pres = 0;
    end else begin
      pres = ((32'd1048576 - ap) - sra32(b, 12)) * 32'd3125;
      if (pres < 32'h8000_0000) pres = (pres << 1) / a;
      else pres = (pres / a) * 32'd2;
      d = ((pres >> 3) * (pres >> 3)) >> 13;
      a = sra32(p9 * d, 12);
      b = sra32((pres >> 2) * p8, 13);
      pres = pres + sra32(a + b + p7, 4);
    end
    r.temperature_centi = temp[23:0];
    r.pressure_pa = pres;
    return r;
  endfunction

  // Result checker: block cannot be stalled, so every done cycle is a word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && done) begin
      comp_result_t got, exp_r;
      got = {temperature_centi, pressure_pa, divide_by_zero};
      results_seen <= results_seen + 1;
      if (divide_by_zero) zero_div_seen <= zero_div_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result word %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: temp exp %h got %h, press exp %h got %h, dz exp %b got %b",
                     exp_r.temperature_centi, got.temperature_centi, exp_r.pressure_pa,
                     got.pressure_pa, exp_r.divide_by_zero, got.divide_by_zero);
        end
      end
    end
  end

  // Send one sample, with random idle cycles ahead of it unless quiet_sender is set.
  task automatic send_sample(logic [19:0] p, logic [19:0] t);
    if (!quiet_sender) begin
      while ($urandom_range(99) < 35) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    raw_pressure <= p;
    raw_temperature <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(compensate(p, t));
    words_sent++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only between phases.
  task automatic write_reg(logic [btpc_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      btpc_pkg::RegTempCal: cal_temp = val[47:0];
      btpc_pkg::RegPressLow: cal_press_low = val;
      btpc_pkg::RegPressHigh: cal_press_high = val;
      default: cal_press_last = val[15:0];
    endcase
  endtask

  task automatic load_typical_cal();
    // T1=27504 T2=26435 T3=-1000; P1=36477 P2=-10173 P3=3024 P4=2855
    write_reg(btpc_pkg::RegTempCal, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
    write_reg(btpc_pkg::RegPressLow, {16'd2855, 16'd3024, 16'hD843, 16'd36477});
    // P5=140 P6=-7 P7=15500 P8=-14600 P9=6000
    write_reg(btpc_pkg::RegPressHigh, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(btpc_pkg::RegPressLast, 64'd6000);
  endtask

  task automatic load_random_cal();
    write_reg(btpc_pkg::RegTempCal, {$urandom, $urandom});
    write_reg(btpc_pkg::RegPressLow, {$urandom, $urandom});
    write_reg(btpc_pkg::RegPressHigh, {$urandom, $urandom});
    write_reg(btpc_pkg::RegPressLast, {$urandom, $urandom});
  endtask

  // Zero calibration straight after reset: divisor is zero everywhere.
  task automatic test_reset_calibration();
    send_sample('0, '0);
    send_sample('1, '1);
    go_idle();
  endtask

  task automatic test_field_extremes();
    logic [19:0] corner[4] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    load_typical_cal();
    foreach (corner[i]) foreach (corner[j]) send_sample(corner[i], corner[j]);
    send_sample(20'd415148, 20'd519888);  // typical room reading
    go_idle();
  endtask

  task automatic test_cal_extremes();
    write_reg(btpc_pkg::RegTempCal, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(btpc_pkg::RegPressLow, '1);
    write_reg(btpc_pkg::RegPressHigh, '1);
    write_reg(btpc_pkg::RegPressLast, 64'h7FFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'd0);
    go_idle();
    write_reg(btpc_pkg::RegTempCal, {16'd0, 16'h7FFF, 16'h8000, 16'h0000});
    write_reg(btpc_pkg::RegPressLow, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF});
    write_reg(btpc_pkg::RegPressHigh, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(btpc_pkg::RegPressLast, 64'h8000);
    send_sample(20'h12345, 20'hABCDE);
    send_sample(20'hFFFFF, 20'd0);
    go_idle();
  endtask

  // Realistic calibration with random samples; one back-to-back stretch.
  task automatic test_random_typical(int n);
    load_typical_cal();
    for (int i = 0; i < n; i++) begin
      quiet_sender = (i >= n / 3 && i < n / 2);
      if ($urandom_range(3) == 0) send_sample(20'($urandom), 20'($urandom));
      else send_sample(20'($urandom_range(300000, 600000)),
                       20'($urandom_range(400000, 650000)));
    end
    quiet_sender = 1'b0;
    go_idle();
  endtask

  task automatic test_random_calibration(int phases, int n);
    for (int k = 0; k < phases; k++) begin
      load_random_cal();
      for (int i = 0; i < n; i++) send_sample(20'($urandom), 20'($urandom));
      go_idle();
    end
  endtask

  initial begin
    cal_temp = '0;
    cal_press_low = '0;
    cal_press_high = '0;
    cal_press_last = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_calibration();
    test_field_extremes();
    test_cal_extremes();
    test_random_typical(500);
    test_random_calibration(10, 28);
    start <= 1'b0;
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d words, %0d results, %0d with zero divisor, over several calibrations",
             words_sent, results_seen, zero_div_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
